>>> sv/gtsp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gtsp_pkg
// Shared types and constants of the text-driven six-channel servo PWM block.
// ============================================================================
package gtsp_pkg;

    // Servo channel count and the channel roles.
    localparam int NUM_CH      = 6;
    localparam int NUM_AXES    = 3;
    localparam int CH_BASE     = 0;
    localparam int CH_SHOULDER = 1;
    localparam int CH_ELBOW    = 2;
    localparam int CH_WRIST    = 3;
    localparam int CH_ROLL     = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PERIOD_TOP     = 3'd0;
    localparam logic [2:0] CFG_DEADBAND_LIMIT = 3'd1;
    localparam logic [2:0] CFG_PULSE_SCALE    = 3'd2;
    localparam logic [2:0] CFG_PULSE_OFFSET   = 3'd3;
    localparam logic [2:0] CFG_PULSE_MIN      = 3'd4;
    localparam logic [2:0] CFG_PULSE_MAX      = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_PERIOD_TOP     = 16'd19999;
    localparam logic [7:0]  RST_DEADBAND_LIMIT = 8'd5;
    localparam logic [7:0]  RST_PULSE_SCALE    = 8'd10;
    localparam logic [15:0] RST_PULSE_OFFSET   = 16'd400;
    localparam logic [15:0] RST_PULSE_MIN      = 16'd400;
    localparam logic [15:0] RST_PULSE_MAX      = 16'd2200;

    // ASCII codes recognized by the line parser.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Axis limit in degrees, and the servo geometry constants.
    localparam int                AXIS_LIMIT     = 90;
    localparam logic signed [8:0] DEG_CENTER     = 9'sd90;
    localparam logic signed [8:0] SHOULDER_BASE  = 9'sd130;
    localparam logic signed [8:0] SHOULDER_FLOOR = 9'sd80;
    localparam logic signed [8:0] ELBOW_BASE     = 9'sd115;
    localparam logic signed [8:0] ELBOW_FLOOR    = 9'sd30;
    localparam logic signed [8:0] WRIST_BASE     = 9'sd90;

    // Queue between the parser and the servo engine.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        AXIS_ROLL  = 2'd0,
        AXIS_PITCH = 2'd1,
        AXIS_YAW   = 2'd2
    } t_axis;

    typedef logic signed [7:0] t_deg;
    typedef t_deg              t_axis_arr [NUM_AXES];
    typedef logic [7:0]        t_angle_arr [NUM_CH];
    typedef logic [15:0]       t_width_arr [NUM_CH];

    localparam t_angle_arr ANGLE_RESET = '{8'd90, 8'd130, 8'd115, 8'd90, 8'd90, 8'd90};

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic  is_tick;
        logic  has_field;
        t_axis axis;
        t_deg  value;
    } t_item;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_status;

    typedef struct packed {
        logic exec;
        logic exec_tick;
    } t_back_status;

endpackage

>>> sv/gtsp_front.sv
`timescale 1ns / 1ps
// ============================================================================
// gtsp_front
// Accepts items, parses the text lines and pushes classified items, with
// finished axis values, into the queue.
// ============================================================================
module gtsp_front #(
    parameter int ACC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_kind,
    input  logic [7:0]             i_rx_byte,
    input  gtsp_pkg::t_fifo_status i_fifo,
    output logic                   o_in_stall,
    output logic                   o_push,
    output gtsp_pkg::t_item        o_item
);

    localparam logic signed [ACC_BITS-1:0] FIELD_HI = ACC_BITS'(gtsp_pkg::AXIS_LIMIT);
    localparam logic signed [ACC_BITS-1:0] FIELD_LO = ACC_BITS'(-gtsp_pkg::AXIS_LIMIT);

    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic                r_neg, n_neg;
    logic                r_next_roll, n_next_roll;

    logic                       w_accept;
    logic                       w_digit, w_minus, w_comma, w_newline;
    logic [3:0]                 w_digit_val;
    logic signed [ACC_BITS-1:0] w_signed;
    gtsp_pkg::t_deg             w_field;

    // The queue alone holds the input side back.
    assign o_in_stall = i_fifo.full;
    assign w_accept   = i_in_valid && !i_fifo.full;
    assign o_push     = w_accept;

    // Byte classification.
    assign w_digit     = i_kind && (i_rx_byte >= gtsp_pkg::CHAR_ZERO)
                                && (i_rx_byte <= gtsp_pkg::CHAR_NINE);
    assign w_minus     = i_kind && (i_rx_byte == gtsp_pkg::CHAR_MINUS);
    assign w_comma     = i_kind && (i_rx_byte == gtsp_pkg::CHAR_COMMA);
    assign w_newline   = i_kind && (i_rx_byte == gtsp_pkg::CHAR_NEWLINE);
    assign w_digit_val = 4'(i_rx_byte - gtsp_pkg::CHAR_ZERO);

    // Field value: apply the sign, read as two's complement, clamp to the axis limit.
    always_comb begin
        w_signed = r_neg ? signed'(ACC_BITS'(0) - r_acc) : signed'(r_acc);
        if (w_signed > FIELD_HI) begin
            w_field = gtsp_pkg::t_deg'(gtsp_pkg::AXIS_LIMIT);
        end else if (w_signed < FIELD_LO) begin
            w_field = gtsp_pkg::t_deg'(-gtsp_pkg::AXIS_LIMIT);
        end else begin
            w_field = w_signed[7:0];
        end
    end

    // Item pushed into the queue.
    always_comb begin
        o_item.is_tick   = !i_kind;
        o_item.has_field = w_comma || w_newline;
        o_item.value     = w_field;
        if (w_newline) begin
            o_item.axis = gtsp_pkg::AXIS_YAW;
        end else if (r_next_roll) begin
            o_item.axis = gtsp_pkg::AXIS_ROLL;
        end else begin
            o_item.axis = gtsp_pkg::AXIS_PITCH;
        end
    end

    // Parser state update.
    always_comb begin
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_next_roll = r_next_roll;
        priority if (w_digit) begin
            n_acc = ACC_BITS'({r_acc, 3'b000}) + ACC_BITS'({r_acc, 1'b0})
                  + ACC_BITS'(w_digit_val);
        end else if (w_minus) begin
            n_neg = 1'b1;
        end else if (w_comma) begin
            n_acc       = '0;
            n_neg       = 1'b0;
            n_next_roll = !r_next_roll;
        end else if (w_newline) begin
            n_acc = '0;
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_next_roll <= 1'b1;
        end else if (w_accept) begin
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_next_roll <= n_next_roll;
        end
    end

endmodule

>>> sv/gtsp_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// gtsp_fifo
// Short queue of classified items between the parser and the servo engine.
// ============================================================================
module gtsp_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  gtsp_pkg::t_item        i_item,
    input  logic                   i_pop,
    output gtsp_pkg::t_item        o_item,
    output gtsp_pkg::t_fifo_status o_status
);

    localparam int PW = gtsp_pkg::FIFO_PTR_W;
    localparam int CW = gtsp_pkg::FIFO_CNT_W;

    gtsp_pkg::t_item r_slot [gtsp_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_step(input logic [PW-1:0] p);
        return (p == PW'(gtsp_pkg::FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_item          = r_slot[r_rd_ptr];
    assign o_status.full   = (r_count == CW'(gtsp_pkg::FIFO_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.count  = r_count;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_step(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_step(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> sv/gtsp_back.sv
`timescale 1ns / 1ps
// ============================================================================
// gtsp_back
// Servo engine: frame counter, pin levels, axis deadband and angle update,
// per-channel pulse width registers and the result register.
// ============================================================================
module gtsp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [2:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  gtsp_pkg::t_item        i_item,
    input  gtsp_pkg::t_fifo_status i_fifo,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [5:0]             o_pin_levels,
    output gtsp_pkg::t_angle_arr   o_angle,
    output gtsp_pkg::t_back_status o_status
);

    localparam int NC = gtsp_pkg::NUM_CH;
    localparam int NA = gtsp_pkg::NUM_AXES;

    // Configuration registers.
    logic [15:0] r_period_top, r_pulse_offset, r_pulse_min, r_pulse_max;
    logic [7:0]  r_deadband, r_pulse_scale;

    // Engine state.
    logic [15:0]           r_cnt, n_cnt;
    logic [NC-1:0]         r_pins, n_pins;
    gtsp_pkg::t_axis_arr   r_axis, n_axis;
    gtsp_pkg::t_axis_arr   r_acc_axis, n_acc_axis;
    gtsp_pkg::t_angle_arr  r_angle, n_angle;
    gtsp_pkg::t_width_arr  r_width, n_width;
    logic                  r_width_ok;

    // Result register.
    logic                  r_out_valid;
    logic [NC-1:0]         r_out_pins;
    gtsp_pkg::t_angle_arr  r_out_angle;

    logic w_cfg_we, w_exec;
    logic [NA-1:0] w_take;

    assign w_cfg_we = i_cfg_valid;
    assign w_exec   = !i_fifo.empty && (!r_out_valid || !i_out_stall)
                   && (!i_item.is_tick || r_width_ok);
    assign o_pop    = w_exec;

    assign o_status.exec      = w_exec;
    assign o_status.exec_tick = w_exec && i_item.is_tick;

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_out_pins;
    assign o_angle      = r_out_angle;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top   <= gtsp_pkg::RST_PERIOD_TOP;
            r_deadband     <= gtsp_pkg::RST_DEADBAND_LIMIT;
            r_pulse_scale  <= gtsp_pkg::RST_PULSE_SCALE;
            r_pulse_offset <= gtsp_pkg::RST_PULSE_OFFSET;
            r_pulse_min    <= gtsp_pkg::RST_PULSE_MIN;
            r_pulse_max    <= gtsp_pkg::RST_PULSE_MAX;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                gtsp_pkg::CFG_PERIOD_TOP:     r_period_top   <= i_cfg_data;
                gtsp_pkg::CFG_DEADBAND_LIMIT: r_deadband     <= i_cfg_data[7:0];
                gtsp_pkg::CFG_PULSE_SCALE:    r_pulse_scale  <= i_cfg_data[7:0];
                gtsp_pkg::CFG_PULSE_OFFSET:   r_pulse_offset <= i_cfg_data;
                gtsp_pkg::CFG_PULSE_MIN:      r_pulse_min    <= i_cfg_data;
                gtsp_pkg::CFG_PULSE_MAX:      r_pulse_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pulse widths from the current angles: scale, offset, then clamp.
    always_comb begin
        logic [16:0] sum;
        for (int i = 0; i < NC; i++) begin
            sum = {1'b0, {8'd0, r_angle[i]} * {8'd0, r_pulse_scale}}
                + {1'b0, r_pulse_offset};
            if (sum < {1'b0, r_pulse_min}) begin
                n_width[i] = r_pulse_min;
            end else if (sum > {1'b0, r_pulse_max}) begin
                n_width[i] = r_pulse_max;
            end else begin
                n_width[i] = sum[15:0];
            end
        end
    end

    // The width registers take up an angle or configuration change in the cycle
    // after it; ticks wait until they are current again.
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        if (!i_rst_n) begin
            r_width_ok <= 1'b0;
        end else begin
            r_width_ok <= !(w_cfg_we || (w_exec && !i_item.is_tick));
        end
    end

    // Deadband check against the axis values after this byte.
    always_comb begin
        logic signed [8:0] diff;
        logic [8:0]        mag;
        n_axis = r_axis;
        if (i_item.has_field) begin
            unique case (i_item.axis)
                gtsp_pkg::AXIS_ROLL:  n_axis[gtsp_pkg::AXIS_ROLL]  = i_item.value;
                gtsp_pkg::AXIS_PITCH: n_axis[gtsp_pkg::AXIS_PITCH] = i_item.value;
                gtsp_pkg::AXIS_YAW:   n_axis[gtsp_pkg::AXIS_YAW]   = i_item.value;
                default: ;
            endcase
        end
        for (int a = 0; a < NA; a++) begin
            diff      = {r_acc_axis[a][7], r_acc_axis[a]} - {n_axis[a][7], n_axis[a]};
            mag       = diff[8] ? 9'(-diff) : 9'(diff);
            w_take[a] = (mag < {1'b0, r_deadband});
        end
    end

    // Next engine state for a tick or for a byte.
    always_comb begin
        logic signed [8:0] yaw9, roll9, p9, sh9, el9, wr9;
        n_cnt      = r_cnt;
        n_pins     = r_pins;
        n_acc_axis = r_acc_axis;
        n_angle    = r_angle;
        yaw9  = {n_axis[gtsp_pkg::AXIS_YAW][7], n_axis[gtsp_pkg::AXIS_YAW]};
        roll9 = {n_axis[gtsp_pkg::AXIS_ROLL][7], n_axis[gtsp_pkg::AXIS_ROLL]};
        p9    = {n_axis[gtsp_pkg::AXIS_PITCH][7], n_axis[gtsp_pkg::AXIS_PITCH]};
        sh9   = gtsp_pkg::SHOULDER_BASE + p9;
        el9   = (p9 > 0) ? gtsp_pkg::ELBOW_BASE - p9 : gtsp_pkg::ELBOW_BASE + p9;
        wr9   = (p9 > 0) ? gtsp_pkg::WRIST_BASE - p9 : gtsp_pkg::WRIST_BASE + p9;
        if (i_item.is_tick) begin
            // Frame counter wrap raises every pin; each pin drops at its width.
            if (r_cnt >= r_period_top) begin
                n_cnt  = '0;
                n_pins = '1;
            end else begin
                n_cnt = r_cnt + 16'd1;
            end
            for (int i = 0; i < NC; i++) begin
                if (n_cnt >= r_width[i]) begin
                    n_pins[i] = 1'b0;
                end
            end
        end else begin
            if (w_take[gtsp_pkg::AXIS_YAW]) begin
                n_angle[gtsp_pkg::CH_BASE]     = 8'(yaw9 + gtsp_pkg::DEG_CENTER);
                n_acc_axis[gtsp_pkg::AXIS_YAW] = n_axis[gtsp_pkg::AXIS_YAW];
            end
            if (w_take[gtsp_pkg::AXIS_ROLL]) begin
                n_angle[gtsp_pkg::CH_ROLL]      = 8'(roll9 + gtsp_pkg::DEG_CENTER);
                n_acc_axis[gtsp_pkg::AXIS_ROLL] = n_axis[gtsp_pkg::AXIS_ROLL];
            end
            if (w_take[gtsp_pkg::AXIS_PITCH]) begin
                // Pitch leans the arm; a zero pitch leaves it where it is.
                if (p9 > 0) begin
                    n_angle[gtsp_pkg::CH_ELBOW] = el9[7:0];
                    n_angle[gtsp_pkg::CH_WRIST] = wr9[7:0];
                end else if (p9 < 0) begin
                    n_angle[gtsp_pkg::CH_SHOULDER] =
                        (sh9 > gtsp_pkg::SHOULDER_FLOOR) ? sh9[7:0]
                                                         : gtsp_pkg::SHOULDER_FLOOR[7:0];
                    n_angle[gtsp_pkg::CH_ELBOW] =
                        (el9 > gtsp_pkg::ELBOW_FLOOR) ? el9[7:0]
                                                      : gtsp_pkg::ELBOW_FLOOR[7:0];
                    n_angle[gtsp_pkg::CH_WRIST] = wr9[7:0];
                end
                n_acc_axis[gtsp_pkg::AXIS_PITCH] = n_axis[gtsp_pkg::AXIS_PITCH];
            end
        end
    end

    // Engine state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pins     <= '0;
            r_axis     <= '{default: '0};
            r_acc_axis <= '{default: '0};
            r_angle    <= gtsp_pkg::ANGLE_RESET;
        end else if (w_exec) begin
            r_cnt  <= n_cnt;
            r_pins <= n_pins;
            if (!i_item.is_tick) begin
                r_axis <= n_axis;
            end
            r_acc_axis <= n_acc_axis;
            r_angle    <= n_angle;
        end
    end

    // Result register: loads on every executed item, frees on a transfer.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_pins  <= n_pins;
            r_out_angle <= n_angle;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> sv/gyro_text_to_servo_pwm.sv
`timescale 1ns / 1ps
// ============================================================================
// gyro_text_to_servo_pwm
// Six-channel RC servo PWM generator steered by "roll,pitch,yaw" text lines.
//
// Each input item is a timer tick (kind 0) or a received text byte (kind 1),
// and each one yields exactly one result: the six pin levels and the six servo
// angles after that item. The block takes one item per clock while neither the
// queue nor the output stalls; a byte or a configuration write makes the next
// tick wait while the per-channel pulse width registers (angle times scale
// plus offset, clamped) are recomputed. The parser pushes into a two-entry
// queue, and the servo engine executes from it into an output register, so
// each side can stall without holding the other.
// There is no clearing pass after reset. Write configuration only while no
// item is in flight; register indexes six and seven are ignored.
// ============================================================================
module gyro_text_to_servo_pwm #(
    parameter int ACC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    // Result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_pin_levels,
    output logic [7:0]  o_angle_ch0,
    output logic [7:0]  o_angle_ch1,
    output logic [7:0]  o_angle_ch2,
    output logic [7:0]  o_angle_ch3,
    output logic [7:0]  o_angle_ch4,
    output logic [7:0]  o_angle_ch5,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    gtsp_pkg::t_fifo_status w_fifo;
    gtsp_pkg::t_item        w_push_item, w_head_item;
    gtsp_pkg::t_back_status w_back;
    gtsp_pkg::t_angle_arr   w_angle;
    logic                   w_push, w_pop;

    // Registers are writable at any time.
    assign o_cfg_ready = 1'b1;

    gtsp_front #(
        .ACC_BITS (ACC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .i_fifo     (w_fifo),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    gtsp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_fifo)
    );

    gtsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (w_head_item),
        .i_fifo       (w_fifo),
        .o_pop        (w_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pin_levels (o_pin_levels),
        .o_angle      (w_angle),
        .o_status     (w_back)
    );

    assign o_angle_ch0 = w_angle[0];
    assign o_angle_ch1 = w_angle[1];
    assign o_angle_ch2 = w_angle[2];
    assign o_angle_ch3 = w_angle[3];
    assign o_angle_ch4 = w_angle[4];
    assign o_angle_ch5 = w_angle[5];

`ifndef SYNTHESIS
    // A tick never runs on width registers left stale by a configuration write.
    a_no_tick_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !w_back.exec_tick)
        else $error("tick executed with stale pulse widths");

    // Every executed item shows up as a pending result on the next cycle.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back.exec |=> o_out_valid)
        else $error("executed item produced no result");

    // The queue never holds more than its depth and never pops when empty.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo.count <= gtsp_pkg::FIFO_CNT_W'(gtsp_pkg::FIFO_DEPTH))
        && !(w_pop && w_fifo.empty))
        else $error("queue count out of range");
`endif

endmodule

>>> verif/gyro_text_to_servo_pwm_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gyro_text_to_servo_pwm_tb
// Self-checking bench for the text-driven six-channel servo PWM generator.
//
// A behavioral copy of the servo state runs next to the block: every accepted
// tick or text byte advances it, and the pin levels and angles it expects are
// queued. Each result transfer is compared against the oldest entry. A short
// directed section covers the parser, the deadband and the angle floors. Four
// register settings follow, each with random traffic under its own mix of
// sender gaps and receiver stalls.
// ============================================================================
module gyro_text_to_servo_pwm_tb;

    // Register index that the block does not implement.
    localparam logic [2:0] CFG_SPARE  = 3'd6;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [5:0]                      pins;
        logic [gtsp_pkg::NUM_CH-1:0][7:0] angles;
    } t_servo_result;

    // Block ports.
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_pin_levels;
    logic [7:0]  o_angle_ch0;
    logic [7:0]  o_angle_ch1;
    logic [7:0]  o_angle_ch2;
    logic [7:0]  o_angle_ch3;
    logic [7:0]  o_angle_ch4;
    logic [7:0]  o_angle_ch5;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Expected servo state and register copies.
    logic [15:0] cfg_top;
    logic [7:0]  cfg_deadband;
    logic [7:0]  cfg_scale;
    logic [15:0] cfg_offset;
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [15:0] frame_cnt;
    logic [5:0]  pin_lvl;
    logic [15:0] digit_acc;
    logic        minus_seen;
    logic        roll_next;
    int          axis_val  [gtsp_pkg::NUM_AXES];
    int          axis_kept [gtsp_pkg::NUM_AXES];
    int          servo_deg [gtsp_pkg::NUM_CH];

    t_servo_result expected_q[$];
    int            mismatch_cnt;
    int            results_seen;
    int            items_sent;
    int            idle_cycles;
    int            sender_idle_pct;
    int            receiver_stall_pct;

    gyro_text_to_servo_pwm u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pin_levels (o_pin_levels),
        .o_angle_ch0  (o_angle_ch0),
        .o_angle_ch1  (o_angle_ch1),
        .o_angle_ch2  (o_angle_ch2),
        .o_angle_ch3  (o_angle_ch3),
        .o_angle_ch4  (o_angle_ch4),
        .o_angle_ch5  (o_angle_ch5),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Signed field value of the digits gathered so far, limited to +-90 degrees.
    function automatic int field_degrees();
        logic [15:0] raw;
        int          deg;
        raw = minus_seen ? -digit_acc : digit_acc;
        deg = $signed(raw);
        if (deg < -gtsp_pkg::AXIS_LIMIT) deg = -gtsp_pkg::AXIS_LIMIT;
        if (deg > gtsp_pkg::AXIS_LIMIT) deg = gtsp_pkg::AXIS_LIMIT;
        return deg;
    endfunction

    // An axis is taken only when it moved less than the deadband limit.
    function automatic bit axis_moves(input gtsp_pkg::t_axis ax);
        int gap;
        gap = axis_kept[ax] - axis_val[ax];
        if (gap < 0) gap = -gap;
        return gap < int'(cfg_deadband);
    endfunction

    // Advance the expected state by one tick or one byte and return its result.
    function automatic t_servo_result step_servo_model(input logic kind,
                                                       input logic [7:0] rx);
        t_servo_result res;
        logic [31:0]   width;
        int            p;
        if (!kind) begin
            if (frame_cnt >= cfg_top) begin
                frame_cnt = '0;
                pin_lvl   = '1;
            end else begin
                frame_cnt = frame_cnt + 16'd1;
            end
            // The lower clamp wins when the limits are crossed.
            for (int ch = 0; ch < gtsp_pkg::NUM_CH; ch++) begin
                width = (servo_deg[ch] & 32'hFF) * cfg_scale + cfg_offset;
                if (width < cfg_min) width = cfg_min;
                else if (width > cfg_max) width = cfg_max;
                if ({16'd0, frame_cnt} >= width) pin_lvl[ch] = 1'b0;
            end
        end else begin
            if (rx >= gtsp_pkg::CHAR_ZERO && rx <= gtsp_pkg::CHAR_NINE) begin
                digit_acc = digit_acc * 16'd10 + {8'd0, rx - gtsp_pkg::CHAR_ZERO};
            end else if (rx == gtsp_pkg::CHAR_MINUS) begin
                minus_seen = 1'b1;
            end else if (rx == gtsp_pkg::CHAR_COMMA) begin
                axis_val[roll_next ? gtsp_pkg::AXIS_ROLL : gtsp_pkg::AXIS_PITCH] =
                    field_degrees();
                roll_next  = !roll_next;
                minus_seen = 1'b0;
                digit_acc  = '0;
            end else if (rx == gtsp_pkg::CHAR_NEWLINE) begin
                axis_val[gtsp_pkg::AXIS_YAW] = field_degrees();
                minus_seen = 1'b0;
                digit_acc  = '0;
            end
            // Every byte re-evaluates all three axes against the deadband.
            if (axis_moves(gtsp_pkg::AXIS_YAW)) begin
                servo_deg[gtsp_pkg::CH_BASE] = axis_val[gtsp_pkg::AXIS_YAW]
                                             + gtsp_pkg::DEG_CENTER;
                axis_kept[gtsp_pkg::AXIS_YAW] = axis_val[gtsp_pkg::AXIS_YAW];
            end
            if (axis_moves(gtsp_pkg::AXIS_ROLL)) begin
                servo_deg[gtsp_pkg::CH_ROLL] = axis_val[gtsp_pkg::AXIS_ROLL]
                                             + gtsp_pkg::DEG_CENTER;
                axis_kept[gtsp_pkg::AXIS_ROLL] = axis_val[gtsp_pkg::AXIS_ROLL];
            end
            if (axis_moves(gtsp_pkg::AXIS_PITCH)) begin
                p = axis_val[gtsp_pkg::AXIS_PITCH];
                if (p > 0) begin
                    servo_deg[gtsp_pkg::CH_ELBOW] = gtsp_pkg::ELBOW_BASE - p;
                    servo_deg[gtsp_pkg::CH_WRIST] = gtsp_pkg::WRIST_BASE - p;
                end else if (p < 0) begin
                    servo_deg[gtsp_pkg::CH_SHOULDER] =
                        (gtsp_pkg::SHOULDER_BASE + p > gtsp_pkg::SHOULDER_FLOOR) ?
                        gtsp_pkg::SHOULDER_BASE + p : gtsp_pkg::SHOULDER_FLOOR;
                    servo_deg[gtsp_pkg::CH_ELBOW] =
                        (gtsp_pkg::ELBOW_BASE + p > gtsp_pkg::ELBOW_FLOOR) ?
                        gtsp_pkg::ELBOW_BASE + p : gtsp_pkg::ELBOW_FLOOR;
                    servo_deg[gtsp_pkg::CH_WRIST] = gtsp_pkg::WRIST_BASE + p;
                end
                axis_kept[gtsp_pkg::AXIS_PITCH] = p;
            end
        end
        res.pins = pin_lvl;
        for (int ch = 0; ch < gtsp_pkg::NUM_CH; ch++) res.angles[ch] = servo_deg[ch][7:0];
        return res;
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Offer one item, wait for its transfer, then by chance leave a random gap.
    task automatic push_item(input logic kind, input logic [7:0] rx);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(step_servo_model(kind, rx));
        items_sent++;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Send one text field: optional minus, decimal digits, then the separator.
    task automatic send_field(input int val, input logic [7:0] term);
        string digits;
        if (val < 0) push_item(1'b1, gtsp_pkg::CHAR_MINUS);
        digits = $sformatf("%0d", (val < 0) ? -val : val);
        for (int k = 0; k < digits.len(); k++) push_item(1'b1, digits[k]);
        push_item(1'b1, term);
    endtask

    // Hold the sender until every queued result has been seen.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            gtsp_pkg::CFG_PERIOD_TOP:     cfg_top      = data;
            gtsp_pkg::CFG_DEADBAND_LIMIT: cfg_deadband = data[7:0];
            gtsp_pkg::CFG_PULSE_SCALE:    cfg_scale    = data[7:0];
            gtsp_pkg::CFG_PULSE_OFFSET:   cfg_offset   = data;
            gtsp_pkg::CFG_PULSE_MIN:      cfg_min      = data;
            gtsp_pkg::CFG_PULSE_MAX:      cfg_max      = data;
            default: ;
        endcase
    endtask

    // The eight-bit registers get random upper bits, which must be dropped.
    task automatic configure(input logic [15:0] top, input logic [7:0] deadband,
                             input logic [7:0] scale, input logic [15:0] offset,
                             input logic [15:0] pmin, input logic [15:0] pmax);
        write_reg(gtsp_pkg::CFG_PERIOD_TOP, top);
        write_reg(gtsp_pkg::CFG_DEADBAND_LIMIT, {8'($urandom_range(255)), deadband});
        write_reg(gtsp_pkg::CFG_PULSE_SCALE, {8'($urandom_range(255)), scale});
        write_reg(gtsp_pkg::CFG_PULSE_OFFSET, offset);
        write_reg(gtsp_pkg::CFG_PULSE_MIN, pmin);
        write_reg(gtsp_pkg::CFG_PULSE_MAX, pmax);
    endtask

    // Mostly small moves around the kept value, so the deadband lets them in.
    function automatic int pick_axis(input int kept);
        int span;
        span = cfg_deadband;
        case ($urandom_range(9))
            0:       return int'($urandom_range(999999)) - 500000;
            1, 2:    return int'($urandom_range(180)) - gtsp_pkg::AXIS_LIMIT;
            default: return kept + int'($urandom_range(2 * span)) - span;
        endcase
    endfunction

    // Random traffic: tick bursts, whole lines, broken lines and noise bytes.
    task automatic run_traffic(input int n_items, input int idle_pct, input int stall_pct);
        int first_item;
        bit paused;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first_item = items_sent;
        paused     = 1'b0;
        while (items_sent - first_item < n_items) begin
            if (!paused && items_sent - first_item >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 25)) push_item(1'b0, 8'($urandom_range(255)));
                end
                4, 5, 6, 7: begin
                    send_field(pick_axis(axis_kept[gtsp_pkg::AXIS_ROLL]),
                               gtsp_pkg::CHAR_COMMA);
                    send_field(pick_axis(axis_kept[gtsp_pkg::AXIS_PITCH]),
                               gtsp_pkg::CHAR_COMMA);
                    send_field(pick_axis(axis_kept[gtsp_pkg::AXIS_YAW]),
                               gtsp_pkg::CHAR_NEWLINE);
                end
                8: begin
                    send_field(pick_axis(0), $urandom_range(1) ? gtsp_pkg::CHAR_COMMA
                                                               : gtsp_pkg::CHAR_NEWLINE);
                end
                default: begin
                    push_item(1'b1, $urandom_range(3) ? 8'($urandom_range(255)) : CHAR_SPACE);
                end
            endcase
        end
    endtask

    // Reset settings: ticks with junk bytes, one small line and stray bytes.
    task automatic test_line_parsing();
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hFF);
        send_field(3, gtsp_pkg::CHAR_COMMA);
        send_field(-4, gtsp_pkg::CHAR_COMMA);
        send_field(2, gtsp_pkg::CHAR_NEWLINE);
        push_item(1'b1, CHAR_SPACE);
        push_item(1'b1, 8'hFF);
        push_item(1'b1, 8'h00);
    endtask

    // A zero deadband blocks every axis; a full one lets clamped extremes and
    // both pitch floors through. A bare minus gives a zero roll.
    task automatic test_deadband_limits();
        write_reg(gtsp_pkg::CFG_DEADBAND_LIMIT, 16'h0000);
        send_field(1, gtsp_pkg::CHAR_NEWLINE);
        write_reg(gtsp_pkg::CFG_DEADBAND_LIMIT, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hFFFF);
        push_item(1'b1, gtsp_pkg::CHAR_MINUS);
        push_item(1'b1, gtsp_pkg::CHAR_COMMA);
        send_field(-90, gtsp_pkg::CHAR_COMMA);
        send_field(99, gtsp_pkg::CHAR_NEWLINE);
    endtask

    task automatic test_streaming_no_idle();
        configure(16'd120, 8'd255, 8'd1, 16'd0, 16'd20, 16'd150);
        run_traffic(250, 0, 0);
    endtask

    // A period top of one also wraps a counter left above it.
    task automatic test_sender_gaps();
        configure(16'd1, 8'd5, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_traffic(250, 84, 0);
    endtask

    // The minimum sits above the maximum here.
    task automatic test_receiver_stalls();
        configure(16'd60, 8'd20, 8'd1, 16'd0, 16'd40, 16'd20);
        run_traffic(250, 0, 84);
    endtask

    task automatic test_mixed_idling();
        configure(16'hFFFF, 8'd1, 8'd255, 16'd0, 16'hFFFF, 16'd0);
        run_traffic(250, 26, 26);
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_servo_result                    want;
        logic [gtsp_pkg::NUM_CH-1:0][7:0] seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_angle_ch5, o_angle_ch4, o_angle_ch3,
                    o_angle_ch2, o_angle_ch1, o_angle_ch0};
            if (expected_q.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = expected_q.pop_front();
                if (o_pin_levels != want.pins)
                    flag_error($sformatf("result %0d pin_levels: expected %b, actual %b",
                                         results_seen, want.pins, o_pin_levels));
                for (int ch = 0; ch < gtsp_pkg::NUM_CH; ch++) begin
                    if (seen[ch] != want.angles[ch])
                        flag_error($sformatf("result %0d angle_ch%0d: expected %0d, actual %0d",
                                             results_seen, ch, want.angles[ch], seen[ch]));
                end
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("gyro_text_to_servo_pwm regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_kind             = 1'b0;
        i_rx_byte          = 8'h00;
        i_out_stall        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = gtsp_pkg::CFG_PERIOD_TOP;
        i_cfg_data         = 16'h0000;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_cnt       = 0;
        results_seen       = 0;
        items_sent         = 0;
        idle_cycles        = 0;

        // Expected state after reset.
        cfg_top      = gtsp_pkg::RST_PERIOD_TOP;
        cfg_deadband = gtsp_pkg::RST_DEADBAND_LIMIT;
        cfg_scale    = gtsp_pkg::RST_PULSE_SCALE;
        cfg_offset   = gtsp_pkg::RST_PULSE_OFFSET;
        cfg_min      = gtsp_pkg::RST_PULSE_MIN;
        cfg_max      = gtsp_pkg::RST_PULSE_MAX;
        frame_cnt    = '0;
        pin_lvl      = '0;
        digit_acc    = '0;
        minus_seen   = 1'b0;
        roll_next    = 1'b1;
        for (int ax = 0; ax < gtsp_pkg::NUM_AXES; ax++) begin
            axis_val[ax]  = 0;
            axis_kept[ax] = 0;
        end
        for (int ch = 0; ch < gtsp_pkg::NUM_CH; ch++) servo_deg[ch] = gtsp_pkg::ANGLE_RESET[ch];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_line_parsing();
        test_deadband_limits();
        test_streaming_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("gyro_text_to_servo_pwm regression: pass");
        end else begin
            $display("gyro_text_to_servo_pwm regression: fail");
        end
        $finish;
    end

endmodule
